>>> sv/bsq_pkg.sv
// ----------------------------------------------------------------------------
// bsq_pkg
// Shared types and constants for the buzzer service queue.
// ----------------------------------------------------------------------------
package bsq_pkg;

  localparam int MAX_IDS_DEF = 64;
  localparam int CMD_W       = 2;
  localparam int TGT_W       = 6;
  localparam int RID_W       = 6;
  localparam int LEN_W       = 7;

  typedef enum logic [CMD_W-1:0] {
    CMD_GIVE  = 2'd0,
    CMD_SEAT  = 2'd1,
    CMD_KICK  = 2'd2,
    CMD_BRIBE = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_FIX,
    ST_FIX2,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic capture;
    logic exec;
    logic fix;
    logic fix2;
    logic load;
  } ctl_t;

  typedef struct packed {
    logic need_fix;
    logic need_fix2;
    logic out_free;
  } sts_t;

endpackage

>>> sv/bsq_ram.sv
// ----------------------------------------------------------------------------
// bsq_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module bsq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> sv/bsq_ctrl.sv
// ----------------------------------------------------------------------------
// bsq_ctrl
// Command sequencer: capture, execute, link fix-up passes, result load.
// ----------------------------------------------------------------------------
module bsq_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  bsq_pkg::sts_t sts,
  output bsq_pkg::ctl_t ctl
);

  bsq_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bsq_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      bsq_pkg::ST_IDLE: if (in_valid) state_nxt = bsq_pkg::ST_EXEC;
      bsq_pkg::ST_EXEC: state_nxt = sts.need_fix ? bsq_pkg::ST_FIX : bsq_pkg::ST_DONE;
      bsq_pkg::ST_FIX:  state_nxt = sts.need_fix2 ? bsq_pkg::ST_FIX2 : bsq_pkg::ST_DONE;
      bsq_pkg::ST_FIX2: state_nxt = bsq_pkg::ST_DONE;
      bsq_pkg::ST_DONE: if (sts.out_free) state_nxt = bsq_pkg::ST_IDLE;
      default:          state_nxt = bsq_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    ctl      = '0;
    in_ready = 1'b0;
    unique case (state_r)
      bsq_pkg::ST_IDLE: begin
        in_ready    = 1'b1;
        ctl.capture = in_valid;
      end
      bsq_pkg::ST_EXEC: ctl.exec = 1'b1;
      bsq_pkg::ST_FIX:  ctl.fix  = 1'b1;
      bsq_pkg::ST_FIX2: ctl.fix2 = 1'b1;
      bsq_pkg::ST_DONE: ctl.load = sts.out_free;
      default: ;
    endcase
  end

endmodule

>>> sv/bsq_dp.sv
// ----------------------------------------------------------------------------
// bsq_dp
// Queue datapath: link memories, free stack, counters and result register.
// ----------------------------------------------------------------------------
module bsq_dp #(
  parameter int MAX_IDS = bsq_pkg::MAX_IDS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  bsq_pkg::ctl_t              ctl,
  output bsq_pkg::sts_t              sts,
  input  logic [bsq_pkg::CMD_W-1:0]  in_cmd,
  input  logic [bsq_pkg::TGT_W-1:0]  in_target_id,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [bsq_pkg::RID_W-1:0]  out_result_id,
  output logic                       out_ok,
  output logic [bsq_pkg::LEN_W-1:0]  out_queue_length
);

  localparam int IW = $clog2(MAX_IDS);
  localparam int LW = $clog2(MAX_IDS + 1);
  localparam logic [LW-1:0] NIL = LW'(MAX_IDS);

  // memory ports
  logic          nx_we, pv_we, st_we;
  logic [IW-1:0] nx_wa, pv_wa, st_wa, nx_ra, pv_ra, st_ra;
  logic [LW:0]   nx_wd, nx_rd;
  logic [LW-1:0] pv_wd, pv_rd;
  logic [IW-1:0] st_wd, st_rd;

  // state
  logic [LW-1:0] head_r, head_nxt, tail_r, tail_nxt;
  logic [LW-1:0] free_r, free_nxt, iss_r, iss_nxt, wait_r, wait_nxt;
  logic          zero_seen_r, zero_seen_nxt, stk0_wr_r, stk0_wr_nxt;
  bsq_pkg::cmd_t cmd_r;
  logic [bsq_pkg::TGT_W-1:0] tgt_r;
  logic [IW-1:0] id_r, id_nxt;
  logic [LW-1:0] n_r, n_nxt, p_r, p_nxt, oh_r, oh_nxt;
  logic          ok_r, ok_nxt, fix_r, fix_nxt, fix2_r, fix2_nxt;
  logic [IW-1:0] rid_r, rid_nxt;
  logic          out_valid_r;
  logic [bsq_pkg::RID_W-1:0] out_rid_r;
  logic          out_ok_r;
  logic [bsq_pkg::LEN_W-1:0] out_len_r;

  logic [IW-1:0] tgt_ix, gid, push_id;
  logic          known, push;
  logic [31:0]   rid32, wait32;

  bsq_ram #(.WIDTH(LW + 1), .DEPTH(MAX_IDS)) u_next (
    .clk(clk), .we(nx_we), .waddr(nx_wa), .wdata(nx_wd), .raddr(nx_ra), .rdata(nx_rd)
  );
  bsq_ram #(.WIDTH(LW), .DEPTH(MAX_IDS)) u_prev (
    .clk(clk), .we(pv_we), .waddr(pv_wa), .wdata(pv_wd), .raddr(pv_ra), .rdata(pv_rd)
  );
  bsq_ram #(.WIDTH(IW), .DEPTH(MAX_IDS)) u_stack (
    .clk(clk), .we(st_we), .waddr(st_wa), .wdata(st_wd), .raddr(st_ra), .rdata(st_rd)
  );

  assign nx_ra  = (bsq_pkg::cmd_t'(in_cmd) == bsq_pkg::CMD_SEAT) ? head_r[IW-1:0]
                                                                 : IW'(in_target_id);
  assign pv_ra  = IW'(in_target_id);
  assign st_ra  = IW'(free_r - LW'(1));
  assign tgt_ix = IW'(tgt_r);
  assign known  = (32'(tgt_r) < 32'(iss_r)) && (32'(tgt_r) < MAX_IDS) && nx_rd[LW]
                  && ((tgt_r != '0) || zero_seen_r);
  assign gid    = (free_r != '0)
                  ? (((free_r == LW'(1)) && !stk0_wr_r) ? '0 : st_rd)
                  : iss_r[IW-1:0];

  always_comb begin
    head_nxt = head_r;  tail_nxt = tail_r;
    free_nxt = free_r;  iss_nxt  = iss_r;  wait_nxt = wait_r;
    zero_seen_nxt = zero_seen_r;  stk0_wr_nxt = stk0_wr_r;
    id_nxt = id_r;  n_nxt = n_r;  p_nxt = p_r;  oh_nxt = oh_r;
    ok_nxt = ok_r;  rid_nxt = rid_r;  fix_nxt = fix_r;  fix2_nxt = fix2_r;
    nx_we = 1'b0;  nx_wa = id_r;  nx_wd = {1'b0, NIL};
    pv_we = 1'b0;  pv_wa = id_r;  pv_wd = NIL;
    push = 1'b0;   push_id = id_r;

    if (ctl.exec) begin
      ok_nxt   = 1'b0;
      rid_nxt  = '0;
      fix_nxt  = 1'b0;
      fix2_nxt = 1'b0;
      n_nxt    = nx_rd[LW-1:0];
      p_nxt    = pv_rd;
      oh_nxt   = head_r;
      id_nxt   = tgt_ix;
      case (cmd_r)
        bsq_pkg::CMD_GIVE: begin
          if ((free_r != '0) || (32'(iss_r) < MAX_IDS)) begin
            ok_nxt  = 1'b1;
            rid_nxt = gid;
            id_nxt  = gid;
            if (free_r != '0) free_nxt = free_r - LW'(1);
            else              iss_nxt  = iss_r + LW'(1);
            if (gid == '0) zero_seen_nxt = 1'b1;
            nx_we = 1'b1;  nx_wa = gid;  nx_wd = {1'b1, NIL};
            pv_we = 1'b1;  pv_wa = gid;
            if ((head_r == NIL) || (tail_r == NIL)) begin
              pv_wd    = NIL;
              head_nxt = LW'(gid);
            end else begin
              pv_wd   = tail_r;
              p_nxt   = tail_r;
              fix_nxt = 1'b1;
            end
            tail_nxt = LW'(gid);
            wait_nxt = wait_r + LW'(1);
          end
        end
        bsq_pkg::CMD_SEAT: begin
          if ((wait_r != '0) && (head_r != NIL)) begin
            ok_nxt  = 1'b1;
            rid_nxt = head_r[IW-1:0];
            nx_we = 1'b1;  nx_wa = head_r[IW-1:0];
            if (nx_rd[LW-1:0] == NIL) tail_nxt = NIL;
            else begin
              pv_we = 1'b1;  pv_wa = nx_rd[IW-1:0];  pv_wd = NIL;
            end
            head_nxt = nx_rd[LW-1:0];
            push = 1'b1;  push_id = head_r[IW-1:0];
          end
        end
        bsq_pkg::CMD_KICK: begin
          if (known) begin
            ok_nxt = 1'b1;
            nx_we = 1'b1;  nx_wa = tgt_ix;
            if (nx_rd[LW-1:0] == NIL) tail_nxt = pv_rd;
            else begin
              pv_we = 1'b1;  pv_wa = nx_rd[IW-1:0];  pv_wd = pv_rd;
            end
            if (pv_rd == NIL) head_nxt = nx_rd[LW-1:0];
            else              fix_nxt  = 1'b1;
            push = 1'b1;  push_id = tgt_ix;
          end
        end
        default: begin
          if (known) begin
            ok_nxt = 1'b1;
            if (32'(tgt_r) != 32'(head_r)) begin
              nx_we = 1'b1;  nx_wa = tgt_ix;  nx_wd = {1'b1, head_r};
              if (nx_rd[LW-1:0] == NIL) tail_nxt = pv_rd;
              else begin
                pv_we = 1'b1;  pv_wa = nx_rd[IW-1:0];  pv_wd = pv_rd;
              end
              head_nxt = LW'(tgt_ix);
              fix_nxt  = 1'b1;
              fix2_nxt = 1'b1;
            end
          end
        end
      endcase
      if (push) begin
        wait_nxt = wait_r - LW'(1);
        if (32'(free_r) < MAX_IDS) begin
          free_nxt = free_r + LW'(1);
          if (free_r == '0) stk0_wr_nxt = 1'b1;
        end
      end
    end

    if (ctl.fix) begin
      case (cmd_r)
        bsq_pkg::CMD_GIVE: begin
          nx_we = 1'b1;  nx_wa = p_r[IW-1:0];  nx_wd = {1'b1, LW'(id_r)};
        end
        bsq_pkg::CMD_KICK: begin
          nx_we = 1'b1;  nx_wa = p_r[IW-1:0];  nx_wd = {1'b1, n_r};
        end
        bsq_pkg::CMD_BRIBE: begin
          nx_we = (p_r != NIL);  nx_wa = p_r[IW-1:0];  nx_wd = {1'b1, n_r};
          pv_we = (oh_r != NIL); pv_wa = oh_r[IW-1:0]; pv_wd = LW'(id_r);
        end
        default: ;
      endcase
    end

    if (ctl.fix2) begin
      pv_we = 1'b1;  pv_wa = id_r;  pv_wd = NIL;
    end
  end

  assign st_we = push && (32'(free_r) < MAX_IDS);
  assign st_wa = free_r[IW-1:0];
  assign st_wd = push_id;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= NIL;
      tail_r      <= NIL;
      free_r      <= LW'(1);
      iss_r       <= LW'(1);
      wait_r      <= '0;
      zero_seen_r <= 1'b0;
      stk0_wr_r   <= 1'b0;
      fix_r       <= 1'b0;
      fix2_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      free_r      <= free_nxt;
      iss_r       <= iss_nxt;
      wait_r      <= wait_nxt;
      zero_seen_r <= zero_seen_nxt;
      stk0_wr_r   <= stk0_wr_nxt;
      fix_r       <= fix_nxt;
      fix2_r      <= fix2_nxt;
      if (ctl.load)       out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  assign rid32  = 32'(rid_r);
  assign wait32 = 32'(wait_r);

  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      cmd_r <= bsq_pkg::cmd_t'(in_cmd);
      tgt_r <= in_target_id;
    end
    id_r  <= id_nxt;
    n_r   <= n_nxt;
    p_r   <= p_nxt;
    oh_r  <= oh_nxt;
    ok_r  <= ok_nxt;
    rid_r <= rid_nxt;
    if (ctl.load) begin
      out_rid_r <= rid32[bsq_pkg::RID_W-1:0];
      out_ok_r  <= ok_r;
      out_len_r <= wait32[bsq_pkg::LEN_W-1:0];
    end
  end

  assign sts.need_fix  = fix_nxt;
  assign sts.need_fix2 = fix2_r;
  assign sts.out_free  = !out_valid_r || out_ready;

  assign out_valid        = out_valid_r;
  assign out_result_id    = out_rid_r;
  assign out_ok           = out_ok_r;
  assign out_queue_length = out_len_r;

  a_count_balance: assert property (@(posedge clk) disable iff (!rst_n)
    (32'(free_r) + 32'(wait_r)) == 32'(iss_r))
    else $error("free plus waiting differs from issued");
  a_head_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (wait_r == '0) == (head_r == NIL))
    else $error("head and waiting count disagree");
  a_tail_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (wait_r == '0) == (tail_r == NIL))
    else $error("tail and waiting count disagree");
  a_wait_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(wait_r) <= MAX_IDS)
    else $error("waiting count above capacity");

endmodule

>>> sv/buzzer_service_queue.sv
// ----------------------------------------------------------------------------
// buzzer_service_queue
// Ordered queue of ID tokens kept as a doubly linked list with a free stack.
// ----------------------------------------------------------------------------
// Each command returns one result transaction. The link and free-stack
// memories are read at the accepting edge, the EXEC state applies the unlink
// or append, and one or two link fix-up writes follow where a neighbor must
// be patched, since each link memory has a single write port: give onto a
// nonempty queue and kick-out of an ID with a predecessor take one, move to
// front of an ID other than the head takes two. The result is loaded into
// the output register from the DONE state once that register is free. The
// next command is accepted in the cycle after the load, even if that result
// is not yet taken; a result still held in the output register when the
// next one is ready stalls the block. IDs range over 0 to MAX_IDS-1;
// result_id carries the low six bits.
module buzzer_service_queue #(
  parameter int MAX_IDS = bsq_pkg::MAX_IDS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [bsq_pkg::CMD_W-1:0]  in_cmd,
  input  logic [bsq_pkg::TGT_W-1:0]  in_target_id,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [bsq_pkg::RID_W-1:0]  out_result_id,
  output logic                       out_ok,
  output logic [bsq_pkg::LEN_W-1:0]  out_queue_length
);

  bsq_pkg::ctl_t ctl;
  bsq_pkg::sts_t sts;

  bsq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .ctl      (ctl)
  );

  bsq_dp #(.MAX_IDS(MAX_IDS)) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .ctl              (ctl),
    .sts              (sts),
    .in_cmd           (in_cmd),
    .in_target_id     (in_target_id),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_result_id    (out_result_id),
    .out_ok           (out_ok),
    .out_queue_length (out_queue_length)
  );

endmodule
